@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the sieve RTL.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication under an active-low reset.
`define SPSV_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// Next-cycle implication under an active-low reset.
`define SPSV_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define SPSV_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define SPSV_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ rtl/core/spsv_pkg.sv @@
// Shared widths, register codes and control types for the segmented sieve.
// Depends on nothing; imported by every module of the block.
package spsv_pkg;

	localparam int SEG_W   = 42;  // segment bound width
	localparam int PRIME_W = 21;  // base prime width
	localparam int WORD_W  = 64;  // bitmap word width
	localparam int IDX_W   = 6;   // word index width on the result port
	localparam int OFF_W   = PRIME_W + 2;  // offset of a multiple from the segment start
	localparam int ADDR_W  = 4;   // register port address width
	localparam int DATA_W  = 64;  // register port data width

	// Smallest integer the segment may start at.
	localparam int LO_MIN = 2;

	// Register selects, taken from the 8-byte aligned address bit.
	localparam logic REG_SEG_LOW  = 1'b0;
	localparam logic REG_SEG_HIGH = 1'b1;

	// Control from the sequencer to the bitmap store.
	typedef struct packed {
		logic clr;  // mark every word as all candidates
		logic rd;   // registered read of one word
		logic wr;   // write of one word
	} map_ctl_t;

endpackage

@@ rtl/core/segmented_prime_sieve.sv @@
// Segmented sieve top level: register port, sequencer, shared divider and bitmap store.
// Per request: bound setup; when a multiple is to be marked, a divider pass over every
// bound bit, then a bitmap read and a write per multiple.
// The final request then emits the bitmap word by word, plus any wait for the result side.
// Reset (arst_n low, asynchronous): seg_low 2, seg_high 4097, sequencer idle, next
// request starts a new segment.
`include "assert_macros.svh"

module segmented_prime_sieve
	import spsv_pkg::*;
#(
	parameter int SEGMENT_SIZE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	// Register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// Base prime requests
	input  logic [PRIME_W-1:0] base_prime,
	input  logic               last_prime,
	input  logic               prime_valid,
	output logic               prime_ready,
	// Bitmap words
	output logic [IDX_W-1:0]   word_index,
	output logic [WORD_W-1:0]  prime_bits,
	output logic               last_word,
	output logic               word_valid,
	input  logic               word_ready
);

	localparam int MAP_WORDS = (SEGMENT_SIZE + 63) / 64;
	localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int SPAN_W    = $clog2(SEGMENT_SIZE);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LO,
		S_CAP,
		S_CLIP,
		S_CHK,
		S_GO,
		S_DIV,
		S_OFF,
		S_MARK_RD,
		S_MARK_WR,
		S_FIN,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_WAIT
	} state_t;

	state_t             state_q;
	logic [SEG_W-1:0]   seg_low_q;
	logic [SEG_W-1:0]   seg_high_q;
	logic               fresh_q;
	logic [PRIME_W-1:0] p_q;
	logic               last_q;
	logic [SEG_W-1:0]   lo_q;
	logic [SEG_W:0]     cap_q;
	logic [SEG_W-1:0]   hi_q;
	logic [SEG_W-1:0]   sq_q;
	logic               empty_q;
	logic               mark_q;
	logic [SPAN_W-1:0]  span_q;
	logic [PRIME_W-1:0] base_q;
	logic               near_q;
	logic [OFF_W-1:0]   off_q;
	logic [WIDX_W-1:0]  k_q;
	logic               word_valid_q;
	logic [IDX_W-1:0]   word_index_q;
	logic [WORD_W-1:0]  prime_bits_q;
	logic               last_word_q;

	logic               cfg_wr;
	logic               item_acc;
	logic               past_end;
	logic [WIDX_W-1:0]  off_word;
	logic [WIDX_W-1:0]  span_word;
	logic               final_word;
	logic [WORD_W-1:0]  tail_mask;
	logic [WORD_W-1:0]  out_bits;
	logic               div_start;
	logic               div_done;
	logic [PRIME_W-1:0] div_rem;
	map_ctl_t           map_ctl;
	logic [WIDX_W-1:0]  map_addr;
	logic [WORD_W-1:0]  map_wdata;
	logic [WORD_W-1:0]  map_rdata;

	// Register port decode: the 8-byte aligned address bit picks the register.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_SEG_HIGH) ? DATA_W'(seg_high_q) : DATA_W'(seg_low_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_low_q  <= SEG_W'(2);
			seg_high_q <= SEG_W'(4097);
		end else if (cfg_wr) begin
			if (paddr[3] == REG_SEG_HIGH) begin
				seg_high_q <= pwdata[SEG_W-1:0];
			end else begin
				seg_low_q <= pwdata[SEG_W-1:0];
			end
		end
	end

	// Handshake and loop decisions.
	assign prime_ready = (state_q == S_IDLE);
	assign item_acc    = prime_valid && prime_ready;
	assign past_end    = off_q > OFF_W'(span_q);
	assign off_word    = WIDX_W'(off_q >> 6);
	assign span_word   = WIDX_W'(span_q >> 6);
	assign final_word  = empty_q || (k_q == span_word);

	// Bits above the segment end are cleared in its final word.
	assign tail_mask = {WORD_W{1'b1}} >> (6'd63 - span_q[5:0]);
	assign out_bits  = empty_q ? '0 : (final_word ? (map_rdata & tail_mask) : map_rdata);

	// Bitmap store control.
	assign map_ctl.clr = item_acc && fresh_q;
	assign map_ctl.rd  = ((state_q == S_MARK_RD) && !past_end) || (state_q == S_EMIT_RD);
	assign map_ctl.wr  = (state_q == S_MARK_WR);
	assign map_addr    = (state_q == S_EMIT_RD) ? k_q : off_word;
	assign map_wdata   = map_rdata & ~(WORD_W'(1) << off_q[5:0]);

	assign div_start = (state_q == S_GO) && !empty_q && mark_q;

	spsv_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (lo_q),
		.divisor   (p_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	spsv_map #(
		.DEPTH (MAP_WORDS),
		.AW    (WIDX_W)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (map_ctl),
		.addr   (map_addr),
		.wdata  (map_wdata),
		.rdata  (map_rdata)
	);

	// Sequencer: bounds, first multiple, marking walk and word emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fresh_q      <= 1'b1;
			word_valid_q <= 1'b0;
			k_q          <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						p_q     <= base_prime;
						last_q  <= last_prime;
						fresh_q <= 1'b0;
						state_q <= S_LO;
					end
				end
				S_LO: begin
					lo_q    <= (seg_low_q < SEG_W'(LO_MIN)) ? SEG_W'(LO_MIN) : seg_low_q;
					sq_q    <= p_q * p_q;
					state_q <= S_CAP;
				end
				S_CAP: begin
					cap_q   <= {1'b0, lo_q} + (SEG_W + 1)'(SEGMENT_SIZE - 1);
					state_q <= S_CLIP;
				end
				S_CLIP: begin
					hi_q    <= ({1'b0, seg_high_q} > cap_q) ? cap_q[SEG_W-1:0] : seg_high_q;
					state_q <= S_CHK;
				end
				S_CHK: begin
					empty_q <= hi_q < lo_q;
					span_q  <= SPAN_W'(hi_q - lo_q);
					mark_q  <= (p_q >= PRIME_W'(LO_MIN)) && (sq_q <= hi_q);
					state_q <= S_GO;
				end
				S_GO: begin
					state_q <= div_start ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_done) begin
						base_q  <= (div_rem == '0) ? '0 : p_q - div_rem;
						near_q  <= lo_q <= SEG_W'(p_q);
						state_q <= S_OFF;
					end
				end
				S_OFF: begin
					// The prime itself stays a candidate: start one step further.
					off_q   <= OFF_W'(base_q) + (near_q ? OFF_W'(p_q) : '0);
					state_q <= S_MARK_RD;
				end
				S_MARK_RD: begin
					state_q <= past_end ? S_FIN : S_MARK_WR;
				end
				S_MARK_WR: begin
					off_q   <= off_q + OFF_W'(p_q);
					state_q <= S_MARK_RD;
				end
				S_FIN: begin
					k_q <= '0;
					if (last_q) begin
						fresh_q <= 1'b1;
						state_q <= S_EMIT_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					word_valid_q <= 1'b1;
					word_index_q <= IDX_W'(k_q);
					prime_bits_q <= out_bits;
					last_word_q  <= final_word;
					state_q      <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (word_ready) begin
						word_valid_q <= 1'b0;
						if (last_word_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A register write restarts the segment at the next request.
			if (cfg_wr) begin
				fresh_q <= 1'b1;
			end
		end
	end

	assign word_valid = word_valid_q;
	assign word_index = word_index_q;
	assign prime_bits = prime_bits_q;
	assign last_word  = last_word_q;

	// Requests are never taken while a bitmap word is on offer.
	`SPSV_ASSERT_IMP(a_no_overlap, clk, arst_n, word_valid, !prime_ready)
	// An accepted request keeps the block busy in the following cycle.
	`SPSV_ASSERT_NXT(a_busy_after_req, clk, arst_n, prime_valid && prime_ready, !prime_ready)
	// Taking the final word of a segment returns the block to idle.
	`SPSV_ASSERT_NXT(a_idle_after_last, clk, arst_n, word_valid && word_ready && last_word,
		prime_ready && !word_valid)

endmodule

@@ rtl/core/spsv_divider.sv @@
// Iterative restoring divider that returns the remainder of a segment bound by a prime.
// Depends on spsv_pkg; one dividend bit is consumed per cycle.
module spsv_divider
	import spsv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SEG_W-1:0]   dividend,
	input  logic [PRIME_W-1:0] divisor,
	output logic               done,
	output logic [PRIME_W-1:0] remainder
);

	localparam int CNT_W = $clog2(SEG_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SEG_W-1:0]   dvd_q;
	logic [PRIME_W-1:0] rem_q;
	logic [PRIME_W-1:0] dsr_q;
	logic [PRIME_W:0]   trial;
	logic               fits;

	// One restoring step: bring down the next bit and subtract where it fits.
	assign trial = {rem_q, dvd_q[SEG_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SEG_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Partial remainder and the shifting dividend.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? PRIME_W'(trial - {1'b0, dsr_q}) : trial[PRIME_W-1:0];
			dvd_q <= dvd_q << 1;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ rtl/core/spsv_map.sv @@
// Candidate bitmap store: one word written or read per cycle, read data registered.
// Depends on spsv_pkg; per-word valid bits make a cleared word read as all ones.
module spsv_map
	import spsv_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  map_ctl_t          ctl,
	input  logic [AW-1:0]     addr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic              rd_valid_q;
	logic [WORD_W-1:0] rd_word_q;

	// Valid bits: cleared together at a segment start, set by each write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	// Word storage with a registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rd_word_q <= mem[addr];
		end
	end

	// A word not written since the last clear still holds every candidate.
	assign rdata = rd_valid_q ? rd_word_q : {WORD_W{1'b1}};

endmodule

@@ tb/prime_map_checker.sv @@
`timescale 1ns / 1ps
// Checker for the segmented sieve: watches the register port and both request channels,
// keeps its own copy of the candidate bitmap and compares every bitmap word.
// Depends on spsv_pkg for widths and register selects.
module prime_map_checker
	import spsv_pkg::*;
#(
	parameter int SEGMENT_SIZE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	input  logic [DATA_W-1:0]  prdata,
	input  logic               pready,
	input  logic [PRIME_W-1:0] base_prime,
	input  logic               last_prime,
	input  logic               prime_valid,
	input  logic               prime_ready,
	input  logic [IDX_W-1:0]   word_index,
	input  logic [WORD_W-1:0]  prime_bits,
	input  logic               last_word,
	input  logic               word_valid,
	input  logic               word_ready,
	input  logic               closing,
	output int                 failures,
	output int                 words_pending,
	output int                 words_checked
);

	localparam int MAP_DEPTH = 64;
	localparam logic [SEG_W-1:0] RESET_LOW  = 42'd2;
	localparam logic [SEG_W-1:0] RESET_HIGH = 42'd4097;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] bits;
		logic              fin;
	} bitmap_word_t;

	// Bitmap words still owed by the block, oldest first.
	bitmap_word_t expected_words[$];

	logic [WORD_W-1:0] cand_map [MAP_DEPTH];
	logic              restart_pending;
	logic [SEG_W-1:0]  low_reg;
	logic [SEG_W-1:0]  high_reg;
	logic              closed;

	task automatic report(input string msg);
		failures++;
		if (failures <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Apply one base prime request to the bitmap and queue the words it releases.
	task automatic sieve_prime(input logic [PRIME_W-1:0] p, input logic fin);
		logic [63:0] lo, hi, span, m, off, nwords, bits, bit_count;
		bitmap_word_t w;
		lo = (low_reg < LO_MIN) ? 64'(LO_MIN) : 64'(low_reg);
		hi = 64'(high_reg);
		if (hi > lo + SEGMENT_SIZE - 1)
			hi = lo + SEGMENT_SIZE - 1;
		span = (hi < lo) ? 64'd0 : hi - lo + 1;

		// The first request of a segment starts from a full map.
		if (restart_pending) begin
			foreach (cand_map[k])
				cand_map[k] = '1;
			restart_pending = 1'b0;
		end

		// Clear every multiple in the segment except the prime itself.
		if (span != 0 && p >= 2 && 64'(p) * 64'(p) <= hi) begin
			m = ((lo + p - 1) / p) * p;
			if (m == 64'(p))
				m += p;
			while (m <= hi) begin
				off = m - lo;
				if (off < MAP_DEPTH * WORD_W)
					cand_map[off[11:6]][off[5:0]] = 1'b0;
				m += p;
			end
		end

		if (!fin)
			return;
		restart_pending = 1'b1;

		// An empty segment still answers with one empty word.
		if (span == 0) begin
			w.idx  = '0;
			w.bits = '0;
			w.fin  = 1'b1;
			expected_words = {expected_words, w};
			return;
		end

		nwords = (span + 63) >> 6;
		if (nwords > MAP_DEPTH)
			nwords = MAP_DEPTH;
		for (int k = 0; k < nwords; k++) begin
			bits = cand_map[k];
			bit_count = span - 64 * k;
			// Numbers beyond the top of the segment read as zero.
			if (bit_count < 64)
				bits &= (64'd1 << bit_count) - 1;
			w.idx  = IDX_W'(k);
			w.bits = bits;
			w.fin  = (k + 1 == nwords);
			expected_words = {expected_words, w};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		bitmap_word_t want;
		logic [DATA_W-1:0] reg_val;
		if (!arst_n) begin
			low_reg  = RESET_LOW;
			high_reg = RESET_HIGH;
			foreach (cand_map[k])
				cand_map[k] = '1;
			restart_pending = 1'b1;
			expected_words.delete();
			failures      = 0;
			words_checked = 0;
			closed        = 1'b0;
		end else begin
			// Register port: writes restart the segment, reads return the stored bound.
			if (psel && penable && pready) begin
				reg_val = {{(DATA_W-SEG_W){1'b0}},
					(paddr[ADDR_W-1] == REG_SEG_HIGH) ? high_reg : low_reg};
				if (pwrite) begin
					if (paddr[ADDR_W-1] == REG_SEG_HIGH)
						high_reg = pwdata[SEG_W-1:0];
					else
						low_reg = pwdata[SEG_W-1:0];
					restart_pending = 1'b1;
				end else if (prdata !== reg_val) begin
					report($sformatf("Register read at %h: expected %h, got %h",
						paddr, reg_val, prdata));
				end
			end

			// Bitmap words are compared against the oldest expectation.
			if (word_valid && word_ready) begin
				if (expected_words.size() == 0) begin
					report($sformatf("Unexpected bitmap word: index %0d bits %h last %b",
						word_index, prime_bits, last_word));
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					if (word_index !== want.idx || prime_bits !== want.bits ||
							last_word !== want.fin)
						report($sformatf({"Bitmap word mismatch: expected index %0d bits %h ",
							"last %b, got index %0d bits %h last %b"}, want.idx, want.bits,
							want.fin, word_index, prime_bits, last_word));
				end
			end

			if (prime_valid && prime_ready)
				sieve_prime(base_prime, last_prime);

			// Anything still owed at the close of the run is a failure.
			if (closing && !closed) begin
				closed = 1'b1;
				if (expected_words.size() != 0) begin
					failures += expected_words.size();
					$display("%0d bitmap words never arrived", expected_words.size());
				end
			end
		end
		words_pending = expected_words.size();
	end

endmodule

@@ tb/tb_segmented_prime_sieve.sv @@
`timescale 1ns / 1ps
// Top of the segmented sieve testbench: clock, reset, bound writes, base prime requests
// and result back-pressure. Depends on spsv_pkg, segmented_prime_sieve and prime_map_checker.
module tb_segmented_prime_sieve;
	import spsv_pkg::*;

	localparam int SEGMENT_SIZE = 4096;
	localparam logic [ADDR_W-1:0] ADDR_SEG_LOW  = {REG_SEG_LOW, 3'b000};
	localparam logic [ADDR_W-1:0] ADDR_SEG_HIGH = {REG_SEG_HIGH, 3'b000};
	localparam logic [SEG_W-1:0]  SEG_MAX       = '1;
	localparam int DIRECTED_ITEMS = 23;
	localparam int RANDOM_ITEMS   = 387;
	localparam int IDLE_PAUSE     = 32;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic [PRIME_W-1:0] base_prime;
	logic               last_prime;
	logic               prime_valid;
	logic               prime_ready;
	logic [IDX_W-1:0]   word_index;
	logic [WORD_W-1:0]  prime_bits;
	logic               last_word;
	logic               word_valid;
	logic               word_ready;
	logic               closing;

	int failures;
	int words_pending;
	int words_checked;

	bit               calm;
	int               items_sent;
	int               segments_run;
	logic [SEG_W-1:0] cur_low;
	logic [SEG_W-1:0] cur_high;
	int               sieve_list[$];
	int               prime_batch[$];

	segmented_prime_sieve #(
		.SEGMENT_SIZE(SEGMENT_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.base_prime(base_prime),
		.last_prime(last_prime),
		.prime_valid(prime_valid),
		.prime_ready(prime_ready),
		.word_index(word_index),
		.prime_bits(prime_bits),
		.last_word(last_word),
		.word_valid(word_valid),
		.word_ready(word_ready)
	);

	prime_map_checker #(
		.SEGMENT_SIZE(SEGMENT_SIZE)
	) sieve_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.base_prime(base_prime),
		.last_prime(last_prime),
		.prime_valid(prime_valid),
		.prime_ready(prime_ready),
		.word_index(word_index),
		.prime_bits(prime_bits),
		.last_word(last_word),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.closing(closing),
		.failures(failures),
		.words_pending(words_pending),
		.words_checked(words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#400_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Mostly short idle gaps, a few long ones, none at all in calm stretches.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 60);
	endfunction

	function automatic bit divisor_free(input int v);
		if (v < 2)
			return 1'b0;
		for (int d = 2; d * d <= v; d++)
			if (v % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// One register access: setup phase, access phase, then the port returns to idle.
	task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write both bounds, sometimes with junk above bit 41, and maybe read them back.
	task automatic write_bounds(input logic [SEG_W-1:0] lo_val, input logic [SEG_W-1:0] hi_val,
			input bit read_back);
		logic [DATA_W-1:0] junk;
		junk = {$urandom, $urandom};
		if ($urandom_range(0, 2) != 0)
			junk = '0;
		reg_access(1'b1, ADDR_SEG_LOW, {junk[DATA_W-1:SEG_W], lo_val});
		junk = {$urandom, $urandom};
		reg_access(1'b1, ADDR_SEG_HIGH, {junk[DATA_W-1:SEG_W], hi_val});
		cur_low  = lo_val;
		cur_high = hi_val;
		if (read_back) begin
			reg_access(1'b0, ADDR_SEG_LOW, '0);
			reg_access(1'b0, ADDR_SEG_HIGH, '0);
		end
	endtask

	// Present one base prime request and hold it until the block takes it.
	task automatic send_prime(input logic [PRIME_W-1:0] p, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			prime_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		prime_valid <= 1'b1;
		base_prime  <= p;
		last_prime  <= fin;
		@(posedge clk);
		while (!prime_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Send the batch with the final request flagged, then let the bitmap drain.
	task automatic run_segment();
		for (int i = 0; i < prime_batch.size(); i++)
			send_prime(PRIME_W'(prime_batch[i]), i == prime_batch.size() - 1);
		prime_valid <= 1'b0;
		do
			@(negedge clk);
		while (words_pending != 0);
		repeat (IDLE_PAUSE) @(posedge clk);
		segments_run++;
	endtask

	// Result side: ready in runs, broken by random stalls.
	initial begin
		int run_len;
		int stall;
		word_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			run_len = $urandom_range(1, 16);
			stall = pick_gap();
			word_ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			if (stall > 0) begin
				word_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		logic [63:0] lo64, hi64, wide, eff_lo, eff_hi;
		int sel, n, cut, cand, keep_pct;

		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		base_prime  <= '0;
		last_prime  <= 1'b0;
		prime_valid <= 1'b0;
		closing     <= 1'b0;
		calm         = 1'b0;
		items_sent   = 0;
		segments_run = 0;
		cur_low      = 42'd2;
		cur_high     = 42'd4097;
		for (int v = 2; v < 2048; v++)
			if (divisor_free(v))
				sieve_list = {sieve_list, v};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bounds straight out of reset: read them, then a full 4096-number segment with
		// values below 2, composites and one out-of-order value too large to mark.
		reg_access(1'b0, ADDR_SEG_LOW, '0);
		reg_access(1'b0, ADDR_SEG_HIGH, '0);
		prime_batch = '{0, 1, 2, 3, 4, 5, 7, 64, 65, 2097151, 11, 13};
		run_segment();

		// A single number at the very top of the range, with the largest base value first.
		write_bounds(SEG_MAX, SEG_MAX, 1'b1);
		prime_batch = '{2097151, 2, 3};
		run_segment();

		// Empty segments: top below bottom, and a bottom raised above a top of zero.
		write_bounds(42'd100, 42'd50, 1'b0);
		prime_batch = '{2, 3};
		run_segment();
		write_bounds(42'd0, 42'd0, 1'b1);
		prime_batch = '{5};
		run_segment();

		// Exactly one full word, starting from a bottom of one.
		write_bounds(42'd1, 42'd65, 1'b0);
		prime_batch = '{2, 3, 5, 7};
		run_segment();

		// A span far longer than the segment is clipped.
		write_bounds(42'd0, SEG_MAX, 1'b1);
		prime_batch = '{2};
		run_segment();

		// Random segments: mostly ascending prime lists, some cut short, some noise.
		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 99) < 15);

			if ($urandom_range(0, 99) < 85) begin
				sel = $urandom_range(0, 99);
				wide = {$urandom, $urandom};
				if (sel < 50)
					lo64 = $urandom_range(0, 5000);
				else if (sel < 72)
					lo64 = $urandom_range(0, 4000000);
				else if (sel < 95)
					lo64 = wide[SEG_W-1:0];
				else
					lo64 = SEG_MAX - $urandom_range(0, 300);
				sel = $urandom_range(0, 99);
				if (sel < 85)
					hi64 = lo64 + $urandom_range(0, 399);
				else if (sel < 93)
					hi64 = lo64 + $urandom_range(400, 1500);
				else if (sel < 97)
					hi64 = ($urandom_range(0, 1) != 0) ? 64'(SEG_MAX)
						: lo64 + $urandom_range(4096, 20000);
				else
					hi64 = (lo64 > 100) ? lo64 - $urandom_range(1, 100) : 64'd0;
				if (hi64 > SEG_MAX)
					hi64 = SEG_MAX;
				write_bounds(lo64[SEG_W-1:0], hi64[SEG_W-1:0], $urandom_range(0, 3) == 0);
			end

			eff_lo = (cur_low < LO_MIN) ? 64'(LO_MIN) : 64'(cur_low);
			eff_hi = cur_high;
			if (eff_hi > eff_lo + SEGMENT_SIZE - 1)
				eff_hi = eff_lo + SEGMENT_SIZE - 1;
			prime_batch.delete();
			sel = $urandom_range(0, 99);
			if (sel < 85) begin
				// Ascending sieving primes; long lists are thinned to about fifteen.
				n = 0;
				foreach (sieve_list[i])
					if (64'(sieve_list[i]) * 64'(sieve_list[i]) <= eff_hi)
						n++;
				keep_pct = (n <= 24) ? 100 : 1500 / n;
				foreach (sieve_list[i])
					if (64'(sieve_list[i]) * 64'(sieve_list[i]) <= eff_hi &&
							$urandom_range(0, 99) < keep_pct)
						prime_batch = {prime_batch, sieve_list[i]};
				// High segments also meet large sieving primes.
				if (eff_hi > 64'd4194304) begin
					repeat ($urandom_range(0, 3)) begin
						do
							cand = $urandom_range(2049, 2097151) | 1;
						while (!divisor_free(cand));
						if (64'(cand) * 64'(cand) <= eff_hi)
							prime_batch = {prime_batch, cand};
					end
				end
				prime_batch.sort();
				if (prime_batch.size() == 0)
					prime_batch = {prime_batch, 2};
				// Some lists end early.
				if (sel >= 70) begin
					cut = $urandom_range(1, prime_batch.size());
					while (prime_batch.size() > cut)
						void'(prime_batch.pop_back());
				end
			end else begin
				// Noise: values below 2, any 21-bit value, composites, primes in any order.
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 3))
						0: begin
							cand = $urandom_range(0, 1);
						end
						1: begin
							cand = $urandom_range(0, 2097151);
						end
						2: begin
							cand = $urandom_range(2, 90) * $urandom_range(2, 90);
						end
						default: begin
							cand = sieve_list[$urandom_range(0, sieve_list.size() - 1)];
						end
					endcase
					prime_batch = {prime_batch, cand};
				end
			end
			run_segment();
		end
		calm = 1'b0;

		// Close the books and give the verdict.
		closing <= 1'b1;
		repeat (2) @(posedge clk);
		$display("Sieved %0d segments from %0d base prime requests; %0d bitmap words checked.",
			segments_run, items_sent, words_checked);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
